// File: hdl/nfsm_pkg.sv
// ----------------------------------------------------------------------------
// nfsm_pkg
// Shared types, constants and the sine table generator of the frequency
// shift mixer.
// ----------------------------------------------------------------------------
package nfsm_pkg;

	// Default geometry, handed to the top level as parameter defaults.
	localparam int SAMPLE_WIDTH_DEF    = 16;
	localparam int PHASE_WIDTH_DEF     = 32;
	localparam int TABLE_ADDR_BITS_DEF = 10;

	// Fixed field widths.
	localparam int CFG_WIDTH       = 32;
	localparam int CFG_INDEX_WIDTH = 1;
	localparam int PHASE_OUT_WIDTH = 32;

	// Sine samples are Q1.15 with amplitude 32767.
	localparam int SINE_WIDTH  = 16;
	localparam int ROUND_SHIFT = 15;
	localparam int SINE_AMPL   = 32767;

	// pi in Q2.30
	localparam logic [63:0] PI_Q30       = 64'd3373259426;
	localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_PHASE_INC   = 1'b0,
		REG_START_PHASE = 1'b1
	} cfg_reg_t;

	// Load strobes of the pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_load_t;

	// Quarter-wave sine entry k of a table with 2^tab_bits entries.
	// Taylor series through x^15/15! in Q30, evaluated at elaboration.
	function automatic logic signed [SINE_WIDTH-1:0] quarter_sine_f(input int k,
			input int tab_bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic signed [63:0] v;
		logic neg;
		x    = (PI_Q30 * 64'(k)) >> (tab_bits - 1);
		x2   = (x * x) >> 30;
		term = x;
		sum  = signed'(x);
		neg  = 1'b1;
		for (int n = 1; n < 15; n += 2) begin
			term = (term * x2) >> 30;
			term = term / 64'((n + 1) * (n + 2));
			if (neg) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
			neg = !neg;
		end
		if (sum < 0) begin
			sum = 64'sd0;
		end
		v = (sum * 64'(SINE_AMPL) + HALF_Q30) >>> 30;
		if (v > 64'(SINE_AMPL)) begin
			v = 64'(SINE_AMPL);
		end
		return SINE_WIDTH'(v);
	endfunction

endpackage

// File: hdl/nfsm_nco.sv
// ----------------------------------------------------------------------------
// nfsm_nco
// Configuration registers, phase accumulator and table address stage.
// ----------------------------------------------------------------------------
module nfsm_nco #(
	parameter int PHASE_WIDTH     = nfsm_pkg::PHASE_WIDTH_DEF,
	parameter int TABLE_ADDR_BITS = nfsm_pkg::TABLE_ADDR_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [nfsm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [nfsm_pkg::CFG_WIDTH-1:0]         cfg_wdata,
	input  logic                                   accept,
	input  logic                                   restart,
	input  nfsm_pkg::stage_load_t                  load,
	output logic [TABLE_ADDR_BITS-1:0]             addr_s1,
	output logic [nfsm_pkg::PHASE_OUT_WIDTH-1:0]   phase_now_s1
);

	logic [nfsm_pkg::CFG_WIDTH-1:0] inc_q;
	logic [nfsm_pkg::CFG_WIDTH-1:0] start_q;
	logic [PHASE_WIDTH-1:0]         phase_acc_q;
	logic [PHASE_WIDTH-1:0]         ph_cur;
	logic [PHASE_WIDTH-1:0]         ph_next;

	always_comb begin
		ph_cur  = restart ? PHASE_WIDTH'(start_q) : phase_acc_q;
		ph_next = ph_cur + PHASE_WIDTH'(inc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q   <= '0;
			start_q <= '0;
		end else if (cfg_we) begin
			unique case (nfsm_pkg::cfg_reg_t'(cfg_index))
				nfsm_pkg::REG_PHASE_INC:   inc_q   <= cfg_wdata;
				nfsm_pkg::REG_START_PHASE: start_q <= cfg_wdata;
			endcase
		end
	end

	// advance once per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
		end else if (accept) begin
			phase_acc_q <= ph_next;
		end
	end

	always_ff @(posedge clk) begin
		if (load.s1) begin
			addr_s1      <= ph_cur[PHASE_WIDTH-1 -: TABLE_ADDR_BITS];
			phase_now_s1 <= nfsm_pkg::PHASE_OUT_WIDTH'(ph_next);
		end
	end

endmodule

// File: hdl/nfsm_sine_rom.sv
// ----------------------------------------------------------------------------
// nfsm_sine_rom
// Quarter-wave sine table with registered sine and cosine lookup.
// ----------------------------------------------------------------------------
module nfsm_sine_rom #(
	parameter int TABLE_ADDR_BITS = nfsm_pkg::TABLE_ADDR_BITS_DEF
) (
	input  logic                                      clk,
	input  nfsm_pkg::stage_load_t                     load,
	input  logic [TABLE_ADDR_BITS-1:0]                addr,
	output logic signed [nfsm_pkg::SINE_WIDTH-1:0]    sin_s2,
	output logic signed [nfsm_pkg::SINE_WIDTH-1:0]    cos_s2
);

	localparam int QTR = 1 << (TABLE_ADDR_BITS - 2);
	localparam int IW  = TABLE_ADDR_BITS - 1;

	logic signed [nfsm_pkg::SINE_WIDTH-1:0] qtbl [QTR+1];

	for (genvar k = 0; k <= QTR; k++) begin : g_tbl
		assign qtbl[k] = nfsm_pkg::quarter_sine_f(k, TABLE_ADDR_BITS);
	end

	logic [TABLE_ADDR_BITS-1:0]             cos_addr;
	logic [IW-1:0]                          sin_idx;
	logic [IW-1:0]                          cos_idx;
	logic signed [nfsm_pkg::SINE_WIDTH-1:0] sin_raw;
	logic signed [nfsm_pkg::SINE_WIDTH-1:0] cos_raw;

	// fold the full wave onto the quarter table
	always_comb begin
		cos_addr = addr + TABLE_ADDR_BITS'(QTR);
		sin_idx  = addr[TABLE_ADDR_BITS-2] ?
			IW'(QTR) - IW'(addr[TABLE_ADDR_BITS-3:0]) : IW'(addr[TABLE_ADDR_BITS-3:0]);
		cos_idx  = cos_addr[TABLE_ADDR_BITS-2] ?
			IW'(QTR) - IW'(cos_addr[TABLE_ADDR_BITS-3:0]) :
			IW'(cos_addr[TABLE_ADDR_BITS-3:0]);
		sin_raw  = qtbl[sin_idx];
		cos_raw  = qtbl[cos_idx];
	end

	always_ff @(posedge clk) begin
		if (load.s2) begin
			sin_s2 <= addr[TABLE_ADDR_BITS-1] ? -sin_raw : sin_raw;
			cos_s2 <= cos_addr[TABLE_ADDR_BITS-1] ? -cos_raw : cos_raw;
		end
	end

endmodule

// File: hdl/nfsm_cmul.sv
// ----------------------------------------------------------------------------
// nfsm_cmul
// Complex multiply by the conjugate phasor, with rounding and saturation.
// ----------------------------------------------------------------------------
module nfsm_cmul #(
	parameter int SAMPLE_WIDTH = nfsm_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                   clk,
	input  nfsm_pkg::stage_load_t                  load,
	input  logic signed [SAMPLE_WIDTH-1:0]         re_s2,
	input  logic signed [SAMPLE_WIDTH-1:0]         im_s2,
	input  logic signed [nfsm_pkg::SINE_WIDTH-1:0] sin_s2,
	input  logic signed [nfsm_pkg::SINE_WIDTH-1:0] cos_s2,
	output logic signed [SAMPLE_WIDTH-1:0]         out_re_s4,
	output logic signed [SAMPLE_WIDTH-1:0]         out_im_s4
);

	localparam int PW   = SAMPLE_WIDTH + nfsm_pkg::SINE_WIDTH;
	localparam int SUMW = PW + 1;
	localparam int QW   = SUMW - nfsm_pkg::ROUND_SHIFT;
	localparam logic signed [SUMW-1:0] RND_HALF = SUMW'(1 << (nfsm_pkg::ROUND_SHIFT - 1));

	logic signed [PW-1:0]   rc_s3;
	logic signed [PW-1:0]   is_s3;
	logic signed [PW-1:0]   ic_s3;
	logic signed [PW-1:0]   rs_s3;
	logic signed [SUMW-1:0] sum_re;
	logic signed [SUMW-1:0] sum_im;

	// round half up, then clamp to the sample range
	function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat_f(
			input logic signed [SUMW-1:0] s);
		logic signed [SUMW-1:0] t;
		logic signed [QW-1:0]   q;
		logic [QW-SAMPLE_WIDTH:0] top;
		t   = s + RND_HALF;
		q   = QW'(t >>> nfsm_pkg::ROUND_SHIFT);
		top = q[QW-1:SAMPLE_WIDTH-1];
		if (&top || ~|top) begin
			return q[SAMPLE_WIDTH-1:0];
		end else if (q[QW-1]) begin
			return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end
	endfunction

	always_ff @(posedge clk) begin
		if (load.s3) begin
			rc_s3 <= re_s2 * cos_s2;
			is_s3 <= im_s2 * sin_s2;
			ic_s3 <= im_s2 * cos_s2;
			rs_s3 <= re_s2 * sin_s2;
		end
	end

	always_comb begin
		sum_re = SUMW'(rc_s3) + SUMW'(is_s3);
		sum_im = SUMW'(ic_s3) - SUMW'(rs_s3);
	end

	always_ff @(posedge clk) begin
		if (load.s4) begin
			out_re_s4 <= round_sat_f(sum_re);
			out_im_s4 <= round_sat_f(sum_im);
		end
	end

endmodule

// File: hdl/nco_frequency_shift_mixer_core.sv
// ----------------------------------------------------------------------------
// nco_frequency_shift_mixer_core
// Carrier frequency offset corrector: each complex sample is multiplied by
// exp(-j*theta), where theta is a phase accumulator that advances by
// phase_increment per sample (a full turn is 2^PHASE_WIDTH). A sample with
// restart set first loads the accumulator from start_phase. Cos and sin come
// from a quarter-wave Q1.15 sine table addressed by the top TABLE_ADDR_BITS
// phase bits; products are rounded half up and saturated to SAMPLE_WIDTH.
// phase_now returns the accumulator after the advance. The block takes one
// sample per clock while the output is not stalled, and each result passes
// through four register stages (phase/address, table lookup, products,
// round and saturate); the rate is set by the phase add, the only loop in
// the design. Write the configuration registers only while no sample is in
// flight.
// ----------------------------------------------------------------------------
module nco_frequency_shift_mixer_core #(
	parameter int SAMPLE_WIDTH    = nfsm_pkg::SAMPLE_WIDTH_DEF,
	parameter int PHASE_WIDTH     = nfsm_pkg::PHASE_WIDTH_DEF,
	parameter int TABLE_ADDR_BITS = nfsm_pkg::TABLE_ADDR_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [nfsm_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [nfsm_pkg::CFG_WIDTH-1:0]        cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]        in_re,
	input  logic signed [SAMPLE_WIDTH-1:0]        in_im,
	input  logic                                  restart,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]        out_re,
	output logic signed [SAMPLE_WIDTH-1:0]        out_im,
	output logic [nfsm_pkg::PHASE_OUT_WIDTH-1:0]  phase_now
);

	nfsm_pkg::stage_load_t load;

	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic vld_s4;
	logic accept;

	logic signed [SAMPLE_WIDTH-1:0]         re_s1;
	logic signed [SAMPLE_WIDTH-1:0]         im_s1;
	logic signed [SAMPLE_WIDTH-1:0]         re_s2;
	logic signed [SAMPLE_WIDTH-1:0]         im_s2;
	logic [TABLE_ADDR_BITS-1:0]             addr_s1;
	logic [nfsm_pkg::PHASE_OUT_WIDTH-1:0]   phase_now_s1;
	logic [nfsm_pkg::PHASE_OUT_WIDTH-1:0]   phase_now_s2;
	logic [nfsm_pkg::PHASE_OUT_WIDTH-1:0]   phase_now_s3;
	logic [nfsm_pkg::PHASE_OUT_WIDTH-1:0]   phase_now_s4;
	logic signed [nfsm_pkg::SINE_WIDTH-1:0] sin_s2;
	logic signed [nfsm_pkg::SINE_WIDTH-1:0] cos_s2;
	logic signed [SAMPLE_WIDTH-1:0]         out_re_s4;
	logic signed [SAMPLE_WIDTH-1:0]         out_im_s4;

	// A stage loads when it is empty or its contents move on this cycle,
	// so bubbles collapse while the output is stalled.
	always_comb begin
		load.s4  = !vld_s4 || out_ready;
		load.s3  = !vld_s3 || load.s4;
		load.s2  = !vld_s2 || load.s3;
		load.s1  = !vld_s1 || load.s2;
		in_ready = load.s1;
		accept   = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (load.s1) begin
				vld_s1 <= accept;
			end
			if (load.s2) begin
				vld_s2 <= vld_s1;
			end
			if (load.s3) begin
				vld_s3 <= vld_s2;
			end
			if (load.s4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	// carry the sample and phase alongside the table and multiply stages
	always_ff @(posedge clk) begin
		if (load.s1) begin
			re_s1 <= in_re;
			im_s1 <= in_im;
		end
		if (load.s2) begin
			re_s2        <= re_s1;
			im_s2        <= im_s1;
			phase_now_s2 <= phase_now_s1;
		end
		if (load.s3) begin
			phase_now_s3 <= phase_now_s2;
		end
		if (load.s4) begin
			phase_now_s4 <= phase_now_s3;
		end
	end

	nfsm_nco #(
		.PHASE_WIDTH     (PHASE_WIDTH),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_nco (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.accept       (accept),
		.restart      (restart),
		.load         (load),
		.addr_s1      (addr_s1),
		.phase_now_s1 (phase_now_s1)
	);

	nfsm_sine_rom #(
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_rom (
		.clk    (clk),
		.load   (load),
		.addr   (addr_s1),
		.sin_s2 (sin_s2),
		.cos_s2 (cos_s2)
	);

	nfsm_cmul #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_cmul (
		.clk       (clk),
		.load      (load),
		.re_s2     (re_s2),
		.im_s2     (im_s2),
		.sin_s2    (sin_s2),
		.cos_s2    (cos_s2),
		.out_re_s4 (out_re_s4),
		.out_im_s4 (out_im_s4)
	);

	assign out_valid = vld_s4;
	assign out_re    = out_re_s4;
	assign out_im    = out_im_s4;
	assign phase_now = phase_now_s4;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the NCO frequency shift mixer. A short table of
// directed samples and register settings comes first: the extremes of I/Q,
// restart, the 45 degree saturation points, and the min and max increments.
// Random phases follow, each with fresh register values. Every output
// transfer is compared to the value typed in its row, if any, else to an
// in-bench model of phase accumulator, sine table, rounding and saturation.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 7;
	localparam int PIPE_DEPTH   = 4;          // register stages, input to result
	localparam int SETTLE_GAP   = PIPE_DEPTH + 4;
	localparam int IDLE_PCT     = 12;
	localparam int NUM_PHASES   = 8;
	localparam int PHASE_LEN    = 140;
	localparam int CYCLE_LIMIT  = 200000;

	// Sine table geometry and pi in Q2.30 for the table build.
	localparam int LUT_BITS = 10;
	localparam int LUT_SIZE = 1 << LUT_BITS;
	localparam int QUARTER  = LUT_SIZE / 4;
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	// One mixer output: corrected I/Q and the accumulator after the advance.
	typedef struct packed {
		logic signed [15:0] out_re;
		logic signed [15:0] out_im;
		logic [31:0]        phase_now;
	} mix_out_t;

	typedef enum logic [1:0] {
		ROW_SAMPLE,
		ROW_SET_INC,
		ROW_SET_START
	} row_kind_t;

	// Directed row: a register write or a sample, with the expected output
	// typed in only where it is obvious by inspection.
	typedef struct packed {
		row_kind_t          kind;
		logic [31:0]        value;
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic               restart;
		logic               typed;
		mix_out_t           want;
	} stim_row_t;

	localparam int DIR_ROWS = 24;

	stim_row_t directed_rows [DIR_ROWS] = '{
		// After reset: zero phase, so cos is full scale and sin is zero.
		'{ROW_SAMPLE, 32'h0, 16'sh7FFF, 16'sh8000, 1'b0, 1'b1,
			'{16'sd32766, -16'sd32767, 32'h0}},
		'{ROW_SAMPLE, 32'h0, 16'sh8000, 16'sh7FFF, 1'b0, 1'b1,
			'{-16'sd32767, 16'sd32766, 32'h0}},
		'{ROW_SAMPLE, 32'h0, 16'sh0000, 16'sh0000, 1'b1, 1'b1,
			'{16'sd0, 16'sd0, 32'h0}},
		'{ROW_SAMPLE, 32'h0, 16'sh0001, 16'shFFFF, 1'b0, 1'b1,
			'{16'sd1, -16'sd1, 32'h0}},
		// 45 degrees, cos equals sin: the real part saturates both ways.
		'{ROW_SET_START, 32'h2000_0000, 16'sh0, 16'sh0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'h0, 16'sh8000, 16'sh8000, 1'b1, 1'b1,
			'{16'sh8000, 16'sd0, 32'h2000_0000}},
		'{ROW_SAMPLE, 32'h0, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1,
			'{16'sh7FFF, 16'sd0, 32'h2000_0000}},
		// Largest increment and start phase: the accumulator wraps each sample.
		'{ROW_SET_INC,   32'hFFFF_FFFF, 16'sh0, 16'sh0, 1'b0, 1'b0, '0},
		'{ROW_SET_START, 32'hFFFF_FFFF, 16'sh0, 16'sh0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'h0, 16'sd12345, -16'sd23456, 1'b1, 1'b0, '0},
		'{ROW_SAMPLE, 32'h0, 16'sh8000, 16'sh0000, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'h0, 16'sh0000, 16'sh7FFF, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'h0, 16'shFFFF, 16'sh0001, 1'b0, 1'b0, '0},
		// Quarter-turn steps: walk all four quadrants of the table.
		'{ROW_SET_INC,   32'h4000_0000, 16'sh0, 16'sh0, 1'b0, 1'b0, '0},
		'{ROW_SET_START, 32'h0000_0000, 16'sh0, 16'sh0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'h0, 16'sd1000, 16'sd2000, 1'b1, 1'b0, '0},
		'{ROW_SAMPLE, 32'h0, 16'sd1000, 16'sd2000, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'h0, -16'sd1000, 16'sd2000, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'h0, 16'sd1000, -16'sd2000, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'h0, -16'sd1000, -16'sd2000, 1'b0, 1'b0, '0},
		// Half-turn steps from 270 degrees.
		'{ROW_SET_INC,   32'h8000_0000, 16'sh0, 16'sh0, 1'b0, 1'b0, '0},
		'{ROW_SET_START, 32'hC000_0000, 16'sh0, 16'sh0, 1'b0, 1'b0, '0},
		'{ROW_SAMPLE, 32'h0, 16'sh8000, 16'sh8000, 1'b1, 1'b0, '0},
		'{ROW_SAMPLE, 32'h0, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0, '0}
	};

	// DUT ports
	logic                                  clk       = 1'b0;
	logic                                  arst_n    = 1'b0;
	logic                                  cfg_we    = 1'b0;
	logic [nfsm_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index = '0;
	logic [nfsm_pkg::CFG_WIDTH-1:0]        cfg_wdata = '0;
	logic                                  in_valid  = 1'b0;
	logic                                  in_ready;
	logic signed [15:0]                    in_re     = '0;
	logic signed [15:0]                    in_im     = '0;
	logic                                  restart   = 1'b0;
	logic                                  out_valid;
	logic                                  out_ready = 1'b0;
	logic signed [15:0]                    out_re;
	logic signed [15:0]                    out_im;
	logic [nfsm_pkg::PHASE_OUT_WIDTH-1:0]  phase_now;

	// Model state: its own copy of the registers and the accumulator.
	logic signed [15:0] sine_lut [LUT_SIZE];
	logic [31:0]        phase_inc_reg   = '0;
	logic [31:0]        start_phase_reg = '0;
	logic [31:0]        nco_phase       = '0;

	mix_out_t    expected_mix [$];
	bit          no_idle       = 1'b0;
	int          fail_count    = 0;
	int          sample_count  = 0;
	int          restart_count = 0;
	int          write_count   = 0;
	int          checked_count = 0;
	int unsigned cycle_count   = 0;

	nco_frequency_shift_mixer_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_re     (in_re),
		.in_im     (in_im),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_re    (out_re),
		.out_im    (out_im),
		.phase_now (phase_now)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Quarter-wave sine sample k: Taylor series to the x^15 term in Q30,
	// truncating after each multiply and each divide, then scaled to Q1.15.
	function automatic logic signed [15:0] taylor_quarter(input int unsigned k);
		longint unsigned ang;
		longint unsigned ang_sq;
		longint unsigned term;
		longint          acc;
		longint          scaled;
		ang    = (PI_Q30 * longint'(k)) / longint'(2 * QUARTER);
		ang_sq = (ang * ang) >> 30;
		term   = ang;
		acc    = longint'(ang);
		for (int n = 1; n < 15; n += 2) begin
			term = ((term * ang_sq) >> 30) / longint'((n + 1) * (n + 2));
			// odd powers alternate in sign: x^3 subtracts, x^5 adds, ...
			if (n % 4 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		scaled = (acc * 32767 + 64'sd536870912) >>> 30;
		if (scaled > 32767) begin
			scaled = 32767;
		end
		return 16'(scaled);
	endfunction

	// Round half up at bit 15, then clamp to the signed 16-bit range.
	function automatic logic signed [15:0] round_q15(input longint acc);
		longint q;
		q = (acc + 64'sd16384) >>> 15;
		if (q > 32767) begin
			q = 32767;
		end else if (q < -32768) begin
			q = -32768;
		end
		return 16'(q);
	endfunction

	// Mix one sample by exp(-j*theta) and advance the accumulator.
	function automatic mix_out_t nco_mix(input logic signed [15:0] re,
			input logic signed [15:0] im, input logic rst);
		logic [LUT_BITS-1:0] sin_addr;
		logic [LUT_BITS-1:0] cos_addr;
		longint              c;
		longint              s;
		mix_out_t            res;
		if (rst) begin
			nco_phase = start_phase_reg;
		end
		sin_addr = nco_phase[31 -: LUT_BITS];
		cos_addr = sin_addr + LUT_BITS'(QUARTER);
		s = sine_lut[sin_addr];
		c = sine_lut[cos_addr];
		res.out_re = round_q15(longint'(re) * c + longint'(im) * s);
		res.out_im = round_q15(longint'(im) * c - longint'(re) * s);
		nco_phase = nco_phase + phase_inc_reg;
		res.phase_now = nco_phase;
		return res;
	endfunction

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(15))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_phase_word();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'($urandom_range(1, 65535));
			3: return 32'h8000_0000 + 32'($urandom_range(0, 255));
			default: return 32'($urandom);
		endcase
	endfunction

	// Drop valid, hold until every expected result has come back, then let
	// the pipeline empty before anything touches the registers.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_mix.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_GAP) @(posedge clk);
	endtask

	// One register write; the trailing edge keeps back-to-back writes from
	// raising and lowering the enable in the same step.
	task automatic write_reg(input nfsm_pkg::cfg_reg_t idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == nfsm_pkg::REG_PHASE_INC) begin
			phase_inc_reg = val;
		end else begin
			start_phase_reg = val;
		end
		write_count++;
		@(posedge clk);
	endtask

	// Present one sample, hold it until the transfer, then queue what the
	// model says should come out (or the typed value, where one is given).
	task automatic push_sample(input logic signed [15:0] re,
			input logic signed [15:0] im, input logic rst,
			input logic typed, input mix_out_t want);
		mix_out_t model_out;
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_re    <= re;
		in_im    <= im;
		restart  <= rst;
		do begin
			@(posedge clk);
		end while (!in_ready);
		model_out = nco_mix(re, im, rst);
		expected_mix.push_back(typed ? want : model_out);
		sample_count++;
		if (rst) begin
			restart_count++;
		end
	endtask

	// Output side: stall at random, IDLE_PCT percent of the time, except in the steady phase.
	always @(posedge clk) begin
		out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
	end

	// Compare every output transfer with the oldest expectation.
	always @(posedge clk) begin
		mix_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_mix.size() == 0) begin
				$error("unexpected result: re %0d im %0d phase %08h",
					out_re, out_im, phase_now);
				fail_count++;
			end else begin
				want = expected_mix.pop_front();
				checked_count++;
				if (out_re !== want.out_re) begin
					$error("out_re: expected %0d, got %0d", want.out_re, out_re);
					fail_count++;
				end
				if (out_im !== want.out_im) begin
					$error("out_im: expected %0d, got %0d", want.out_im, out_im);
					fail_count++;
				end
				if (phase_now !== want.phase_now) begin
					$error("phase_now: expected %08h, got %08h",
						want.phase_now, phase_now);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: a run that reaches CYCLE_LIMIT is reported as failed.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int unsigned        quad;
		int unsigned        r;
		logic signed [15:0] s;

		// Build the full-wave table from the quarter wave by symmetry.
		for (int k = 0; k < LUT_SIZE; k++) begin
			quad = k / QUARTER;
			r    = k % QUARTER;
			s    = quad[0] ? taylor_quarter(QUARTER - r) : taylor_quarter(r);
			sine_lut[k] = quad[1] ? -s : s;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: register rows wait for the pipeline to go idle.
		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_SET_INC: begin
					settle();
					write_reg(nfsm_pkg::REG_PHASE_INC, directed_rows[i].value);
				end
				ROW_SET_START: begin
					settle();
					write_reg(nfsm_pkg::REG_START_PHASE, directed_rows[i].value);
				end
				default: begin
					push_sample(directed_rows[i].re, directed_rows[i].im,
						directed_rows[i].restart, directed_rows[i].typed,
						directed_rows[i].want);
				end
			endcase
		end

		// Random phases, each with new register values. Phase 2 runs with no
		// idling on either side; phase 5 stops mid-way until all results drain.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			write_reg(nfsm_pkg::REG_PHASE_INC, pick_phase_word());
			write_reg(nfsm_pkg::REG_START_PHASE, pick_phase_word());
			no_idle = (ph == 2);
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (ph == 5 && n == PHASE_LEN / 2) begin
					settle();
				end
				push_sample(pick_sample(), pick_sample(),
					n == 0 || $urandom_range(19) == 0, 1'b0, '0);
			end
			no_idle = 1'b0;
		end

		settle();

		$display("Covered %0d samples (%0d restarts) across %0d register writes;",
			sample_count, restart_count, write_count);
		$display("%0d results compared, %0d field mismatches.",
			checked_count, fail_count);
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/nfsm_pkg.sv
hdl/nfsm_nco.sv
hdl/nfsm_sine_rom.sv
hdl/nfsm_cmul.sv
hdl/nco_frequency_shift_mixer_core.sv
tb/testbench.sv
